FILE: rtl/slfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_pkg
// shared types and codes of the start/length frame receiver
// ----------------------------------------------------------------------------
package slfr_pkg;

   // command codes of an input transfer
   localparam logic [1:0] CMD_ARM     = 2'd0;
   localparam logic [1:0] CMD_RX_BYTE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   // result status codes
   localparam logic [1:0] ST_BYTE     = 2'd0;
   localparam logic [1:0] ST_TIMEOUT  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // register indexes
   localparam logic CSR_DEFAULT_TIMEOUT = 1'b0;
   localparam logic CSR_START_VALUE     = 1'b1;

   // register reset values
   localparam logic [15:0] DEFAULT_TIMEOUT_RESET = 16'd100;
   localparam logic [7:0]  START_VALUE_RESET     = 8'd126;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HUNT   = 2'd1,
      PH_HEADER = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic [15:0] timeout_ms;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [8:0] byte_index;
      logic [1:0] status;
      logic       last;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/start_length_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// start_length_frame_receiver
// hunts for a start byte, passes a length-prefixed frame with byte indexes
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | cmd, data_byte, timeout_ms
//  rsp     | out       | rsp_valid/rsp_ready  | out_byte, byte_index, status, last
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
//  one item per cycle sustained while rsp is not stalled; an item that yields a result
//  passes from its req transfer through the input register, then the result register
//  reset is synchronous: state goes idle, registers return to 100 ms / 0x7e
//  a stalled rsp holds the result register; req keeps flowing while the
//  input register can hand its item on to the result register
// ----------------------------------------------------------------------------
module start_length_frame_receiver import slfr_pkg::*; #(
   parameter int HEADER_BYTES = 4,
   parameter int CRC_BYTES    = 2,
   parameter int MAX_FRAME    = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   // input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [15:0] req_timeout_ms,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [8:0]       rsp_byte_index,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       can_load;
   logic       fire;
   logic       res_valid;
   result_type res;
   result_type rsp;

   assign req_item.cmd        = req_cmd;
   assign req_item.data_byte  = req_data_byte;
   assign req_item.timeout_ms = req_timeout_ms;

   // held item is processed when the result register can take its outcome
   assign fire = item_valid && can_load;

   slfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (can_load),
      .item_valid (item_valid),
      .item       (item)
   );

   // state update and result selection, one item per transfer
   slfr_core #(
      .HEADER_BYTES (HEADER_BYTES),
      .CRC_BYTES    (CRC_BYTES),
      .MAX_FRAME    (MAX_FRAME)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   slfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .res_valid (res_valid),
      .res       (res),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_byte_index = rsp.byte_index;
   assign rsp_status     = rsp.status;
   assign rsp_last       = rsp.last;

endmodule
`default_nettype wire

FILE: rtl/slfr_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_in_stage
// input register that holds one accepted item until the core takes it
// ----------------------------------------------------------------------------
module slfr_in_stage import slfr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire item_type req_item,
   input  wire logic     advance,
   output logic          item_valid,
   output item_type      item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // free when empty or when the held item moves on this cycle
   assign req_ready  = !valid_ff || advance;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/slfr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_core
// receive state machine, timeout counter and configuration registers
// ----------------------------------------------------------------------------
module slfr_core import slfr_pkg::*; #(
   parameter int HEADER_BYTES = 4,
   parameter int CRC_BYTES    = 2,
   parameter int MAX_FRAME    = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        fire,
   input  wire item_type    item,
   output logic             res_valid,
   output result_type       res
);

   localparam logic [9:0]  HDR_LEN  = 10'(HEADER_BYTES);
   localparam logic [9:0]  FIXED    = 10'(HEADER_BYTES + CRC_BYTES);
   localparam logic [10:0] MAX_LEN  = 11'(MAX_FRAME);

   phase_type   phase_ff, phase_in;
   logic [9:0]  byte_count_ff, byte_count_in;
   logic [9:0]  expected_length_ff, expected_length_in;
   logic [15:0] elapsed_ms_ff, elapsed_ms_in;
   logic [15:0] active_timeout_ff, active_timeout_in;
   logic [15:0] default_timeout_ff;
   logic [7:0]  start_value_ff;

   logic [9:0]  count_inc;
   logic [9:0]  total_len;
   logic [15:0] elapsed_inc;

   assign count_inc   = byte_count_ff + 10'd1;
   assign total_len   = FIXED + {2'b00, item.data_byte};
   assign elapsed_inc = (elapsed_ms_ff != 16'hFFFF) ? elapsed_ms_ff + 16'd1 : elapsed_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_timeout_ff <= DEFAULT_TIMEOUT_RESET;
         start_value_ff     <= START_VALUE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEFAULT_TIMEOUT: default_timeout_ff <= csr_wdata;
            CSR_START_VALUE:     start_value_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         byte_count_ff      <= '0;
         expected_length_ff <= '0;
         elapsed_ms_ff      <= '0;
         active_timeout_ff  <= '0;
      end else begin
         phase_ff           <= phase_in;
         byte_count_ff      <= byte_count_in;
         expected_length_ff <= expected_length_in;
         elapsed_ms_ff      <= elapsed_ms_in;
         active_timeout_ff  <= active_timeout_in;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      byte_count_in      = byte_count_ff;
      expected_length_in = expected_length_ff;
      elapsed_ms_in      = elapsed_ms_ff;
      active_timeout_in  = active_timeout_ff;
      res_valid          = 1'b0;
      res.out_byte       = item.data_byte;
      res.byte_index     = byte_count_ff[8:0];
      res.status         = ST_BYTE;
      res.last           = 1'b0;
      if (fire) begin
         case (item.cmd)
            CMD_ARM: begin
               active_timeout_in  = (item.timeout_ms == 16'd0) ? default_timeout_ff
                                                               : item.timeout_ms;
               elapsed_ms_in      = '0;
               byte_count_in      = '0;
               expected_length_in = '0;
               phase_in           = PH_HUNT;
            end
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  elapsed_ms_in = elapsed_inc;
                  if (elapsed_inc >= active_timeout_ff) begin
                     phase_in     = PH_IDLE;
                     res_valid    = 1'b1;
                     res.out_byte = '0;
                     res.status   = ST_TIMEOUT;
                     res.last     = 1'b1;
                  end
               end
            end
            CMD_RX_BYTE: begin
               case (phase_ff)
                  PH_HUNT: begin
                     if (item.data_byte == start_value_ff) begin
                        byte_count_in  = 10'd1;
                        phase_in       = PH_HEADER;
                        res_valid      = 1'b1;
                        res.byte_index = '0;
                     end
                  end
                  PH_HEADER: begin
                     byte_count_in = count_inc;
                     res_valid     = 1'b1;
                     if (count_inc >= HDR_LEN) begin
                        // length byte closes the header
                        expected_length_in = total_len;
                        if ({1'b0, total_len} > MAX_LEN) begin
                           phase_in   = PH_IDLE;
                           res.status = ST_OVERFLOW;
                           res.last   = 1'b1;
                        end else if (count_inc >= total_len) begin
                           phase_in = PH_IDLE;
                           res.last = 1'b1;
                        end else begin
                           phase_in = PH_BODY;
                        end
                     end
                  end
                  PH_BODY: begin
                     byte_count_in = count_inc;
                     res_valid     = 1'b1;
                     if (count_inc >= expected_length_ff) begin
                        phase_in = PH_IDLE;
                        res.last = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/slfr_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_out_stage
// result register toward the rsp channel
// ----------------------------------------------------------------------------
module slfr_out_stage import slfr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic       res_valid,
   input  wire result_type res,
   output logic            can_load,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = can_load ? (load && res_valid) : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid && can_load) begin
         res_ff <= res;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/slfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_checker
// port-level checks on the frame receiver result channel
// ----------------------------------------------------------------------------
module slfr_checker import slfr_pkg::*; #(
   parameter int HEADER_BYTES = 4
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [8:0] rsp_byte_index,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_index) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // error results always end the receive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TIMEOUT || rsp_status == ST_OVERFLOW) |-> rsp_last)
      else $error("error result without last");

   // overflow is only reported on the length byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERFLOW |-> rsp_byte_index == 9'(HEADER_BYTES - 1))
      else $error("overflow away from length byte");

   // timeout results carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_TIMEOUT |-> rsp_out_byte == 8'd0)
      else $error("timeout with nonzero byte");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind start_length_frame_receiver slfr_checker #(
   .HEADER_BYTES (HEADER_BYTES)
) u_slfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_index (rsp_byte_index),
   .rsp_status     (rsp_status),
   .rsp_last       (rsp_last)
);
`default_nettype wire
